/* sv/fqlg_pkg.sv */
package fqlg_pkg;

    // Working width for rounding and clipping: holds every product with room to spare
    localparam int WW  = 66;
    localparam int VW  = 32;   // Q.F value width
    localparam int LW  = 17;   // level / zero-point width
    localparam int DW  = 18;   // level distance width
    localparam int QW  = 19;   // quantized level, only needed while in range

    typedef logic signed [WW-1:0] t_wide;
    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [LW-1:0] t_lvl;
    typedef logic signed [DW-1:0] t_dist;
    typedef logic signed [QW-1:0] t_qlvl;

    localparam t_wide SAT_MAX = t_wide'(64'sd2147483647);
    localparam t_wide SAT_MIN = t_wide'(-64'sd2147483648);
    localparam t_lvl  LEVEL_MAX_RST = t_lvl'(255);
    localparam t_lvl  LEVEL_MIN_RST = t_lvl'(0);
    localparam t_lvl  ZERO_OFF_RST  = t_lvl'(0);

    typedef enum logic [2:0] {
        CFG_STEP_SCALE,
        CFG_STEP_INVERSE,
        CFG_ZERO_OFFSET,
        CFG_LEVEL_MIN,
        CFG_LEVEL_MAX,
        CFG_GRAD_GAIN
    } t_cfg_idx;

    typedef struct packed {
        logic [VW-1:0] step_scale;
        logic [VW-1:0] step_inverse;
        t_lvl          zero_offset;
        t_lvl          level_min;
        t_lvl          level_max;
        logic [VW-1:0] grad_gain;
    } t_cfg;

    typedef struct packed {
        t_val val;
        logic clip;
    } t_sat;

    // Hand-over between the front and back halves of the pipe
    typedef struct packed {
        t_val dy;
        t_val err;
        t_val w;
        t_val dzp;
        logic inr;
        logic f_in;
        logic f_out;
    } t_mid;

    typedef struct packed {
        logic saturated;
        t_val dzp;
        t_val dscale;
        t_val dx;
    } t_res;

    // Round away sh fraction bits, nearest with ties to even
    function automatic t_wide rne(input t_wide v, input int unsigned sh);
        t_wide fl;
        t_wide rem;
        t_wide half;
        t_wide res;
        fl   = v >>> sh;
        rem  = v - (fl <<< sh);
        half = t_wide'(1) <<< (sh - 1);
        res  = fl;
        if (rem > half || (rem == half && fl[0])) begin
            res = fl + t_wide'(1);
        end
        return res;
    endfunction

    // Clip to the signed 32-bit range, flag when clipped
    function automatic t_sat sat32(input t_wide v);
        t_sat s;
        s.clip = 1'b0;
        s.val  = v[VW-1:0];
        if (v > SAT_MAX) begin
            s.clip = 1'b1;
            s.val  = SAT_MAX[VW-1:0];
        end else if (v < SAT_MIN) begin
            s.clip = 1'b1;
            s.val  = SAT_MIN[VW-1:0];
        end
        return s;
    endfunction

endpackage

/* sv/fqlg_front.sv */
module fqlg_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  fqlg_pkg::t_val   i_x,
    input  fqlg_pkg::t_val   i_dy,
    input  fqlg_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output fqlg_pkg::t_mid   o_mid
);

    logic signed [32:0] s_ext;
    logic signed [32:0] r_ext;
    logic signed [32:0] g_ext;

    assign s_ext = $signed({1'b0, i_cfg.step_scale});
    assign r_ext = $signed({1'b0, i_cfg.step_inverse});
    assign g_ext = $signed({1'b0, i_cfg.grad_gain});

    // stage 1: x*r and dy*s
    logic               r_s1_valid;
    logic signed [64:0] r_s1_prx;
    logic signed [64:0] r_s1_pv;
    fqlg_pkg::t_val     r_s1_x;
    fqlg_pkg::t_val     r_s1_dy;

    // stage 2: level, range test, v
    logic               r_s2_valid;
    fqlg_pkg::t_qlvl    r_s2_q;
    logic               r_s2_inr;
    fqlg_pkg::t_dist    r_s2_d;
    fqlg_pkg::t_val     r_s2_v;
    logic               r_s2_fv;
    fqlg_pkg::t_val     r_s2_x;
    fqlg_pkg::t_val     r_s2_dy;

    // stage 3: q*s, dy*d, v*g
    logic               r_s3_valid;
    logic signed [51:0] r_s3_qs;
    logic signed [49:0] r_s3_pw;
    logic signed [64:0] r_s3_pvg;
    logic               r_s3_inr;
    logic               r_s3_fv;
    fqlg_pkg::t_val     r_s3_x;
    fqlg_pkg::t_val     r_s3_dy;

    // stage 4 output
    logic               r_s4_valid;
    fqlg_pkg::t_mid     r_s4_mid;

    fqlg_pkg::t_wide    n_q;
    fqlg_pkg::t_wide    n_xq;
    logic               n_lo_ok;
    logic               n_hi_ok;
    fqlg_pkg::t_dist    n_d;
    fqlg_pkg::t_sat     n_v;
    fqlg_pkg::t_sat     n_err;
    fqlg_pkg::t_sat     n_w;
    fqlg_pkg::t_sat     n_dzp;

    always_comb begin
        n_q     = fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s1_prx), 2 * FRAC_BITS);
        n_xq    = n_q + fqlg_pkg::t_wide'(i_cfg.zero_offset);
        n_lo_ok = n_xq >= fqlg_pkg::t_wide'(i_cfg.level_min);
        n_hi_ok = n_xq <= fqlg_pkg::t_wide'(i_cfg.level_max);
        // below the range takes the low distance, anything else the high one
        if (!n_lo_ok) begin
            n_d = fqlg_pkg::t_dist'(i_cfg.level_min) - fqlg_pkg::t_dist'(i_cfg.zero_offset);
        end else begin
            n_d = fqlg_pkg::t_dist'(i_cfg.level_max) - fqlg_pkg::t_dist'(i_cfg.zero_offset);
        end
        n_v   = fqlg_pkg::sat32(fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s1_pv), FRAC_BITS));
        n_err = fqlg_pkg::sat32(fqlg_pkg::t_wide'(r_s3_qs) - fqlg_pkg::t_wide'(r_s3_x));
        n_w   = fqlg_pkg::sat32(fqlg_pkg::t_wide'(r_s3_pw));
        n_dzp = fqlg_pkg::sat32(-fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s3_pvg), FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_prx <= i_x * r_ext;
            r_s1_pv  <= i_dy * s_ext;
            r_s1_x   <= i_x;
            r_s1_dy  <= i_dy;

            r_s2_q   <= fqlg_pkg::t_qlvl'(n_q);
            r_s2_inr <= n_lo_ok && n_hi_ok;
            r_s2_d   <= n_d;
            r_s2_v   <= n_v.val;
            r_s2_fv  <= n_v.clip;
            r_s2_x   <= r_s1_x;
            r_s2_dy  <= r_s1_dy;

            r_s3_qs  <= r_s2_q * s_ext;
            r_s3_pw  <= r_s2_dy * r_s2_d;
            r_s3_pvg <= r_s2_v * g_ext;
            r_s3_inr <= r_s2_inr;
            r_s3_fv  <= r_s2_fv;
            r_s3_x   <= r_s2_x;
            r_s3_dy  <= r_s2_dy;

            r_s4_mid.dy    <= r_s3_dy;
            r_s4_mid.err   <= n_err.val;
            r_s4_mid.w     <= n_w.val;
            r_s4_mid.dzp   <= n_dzp.val;
            r_s4_mid.inr   <= r_s3_inr;
            r_s4_mid.f_in  <= n_err.clip;
            r_s4_mid.f_out <= r_s3_fv | n_w.clip | n_dzp.clip;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_mid   = r_s4_mid;

endmodule

/* sv/fqlg_back.sv */
module fqlg_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  fqlg_pkg::t_mid   i_mid,
    input  fqlg_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output fqlg_pkg::t_res   o_res
);

    logic signed [32:0] r_ext;
    logic signed [32:0] g_ext;

    assign r_ext = $signed({1'b0, i_cfg.step_inverse});
    assign g_ext = $signed({1'b0, i_cfg.grad_gain});

    // stage 5: dy*err, w*g
    logic               r_s5_valid;
    logic signed [63:0] r_s5_pt;
    logic signed [64:0] r_s5_pwg;
    fqlg_pkg::t_val     r_s5_dy;
    fqlg_pkg::t_val     r_s5_dzp;
    logic               r_s5_inr;
    logic               r_s5_fin;
    logic               r_s5_fout;

    // stage 6: t, clipped-branch dscale
    logic               r_s6_valid;
    fqlg_pkg::t_val     r_s6_t;
    fqlg_pkg::t_val     r_s6_dso;
    fqlg_pkg::t_val     r_s6_dy;
    fqlg_pkg::t_val     r_s6_dzp;
    logic               r_s6_inr;
    logic               r_s6_fin;
    logic               r_s6_fout;

    // stage 7: t*r
    logic               r_s7_valid;
    logic signed [64:0] r_s7_pu;
    fqlg_pkg::t_val     r_s7_dso;
    fqlg_pkg::t_val     r_s7_dy;
    fqlg_pkg::t_val     r_s7_dzp;
    logic               r_s7_inr;
    logic               r_s7_fin;
    logic               r_s7_fout;

    // stage 8: u
    logic               r_s8_valid;
    fqlg_pkg::t_val     r_s8_u;
    fqlg_pkg::t_val     r_s8_dso;
    fqlg_pkg::t_val     r_s8_dy;
    fqlg_pkg::t_val     r_s8_dzp;
    logic               r_s8_inr;
    logic               r_s8_fin;
    logic               r_s8_fout;

    // stage 9: u*g
    logic               r_s9_valid;
    logic signed [64:0] r_s9_pd;
    fqlg_pkg::t_val     r_s9_dso;
    fqlg_pkg::t_val     r_s9_dy;
    fqlg_pkg::t_val     r_s9_dzp;
    logic               r_s9_inr;
    logic               r_s9_fin;
    logic               r_s9_fout;

    // stage 10: result
    logic               r_s10_valid;
    fqlg_pkg::t_res     r_s10_res;

    fqlg_pkg::t_sat     n_t;
    fqlg_pkg::t_sat     n_dso;
    fqlg_pkg::t_sat     n_u;
    fqlg_pkg::t_sat     n_dsi;
    fqlg_pkg::t_res     n_res;

    always_comb begin
        n_t   = fqlg_pkg::sat32(fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s5_pt), FRAC_BITS));
        n_dso = fqlg_pkg::sat32(fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s5_pwg), FRAC_BITS));
        n_u   = fqlg_pkg::sat32(fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s7_pu), FRAC_BITS));
        n_dsi = fqlg_pkg::sat32(fqlg_pkg::rne(fqlg_pkg::t_wide'(r_s9_pd), FRAC_BITS));
        // pick the branch that the range test chose
        if (r_s9_inr) begin
            n_res.dx        = r_s9_dy;
            n_res.dscale    = n_dsi.val;
            n_res.dzp       = '0;
            n_res.saturated = r_s9_fin | n_dsi.clip;
        end else begin
            n_res.dx        = '0;
            n_res.dscale    = r_s9_dso;
            n_res.dzp       = r_s9_dzp;
            n_res.saturated = r_s9_fout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
        end else if (i_en) begin
            r_s5_valid  <= i_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_pt   <= i_mid.dy * i_mid.err;
            r_s5_pwg  <= i_mid.w * g_ext;
            r_s5_dy   <= i_mid.dy;
            r_s5_dzp  <= i_mid.dzp;
            r_s5_inr  <= i_mid.inr;
            r_s5_fin  <= i_mid.f_in;
            r_s5_fout <= i_mid.f_out;

            r_s6_t    <= n_t.val;
            r_s6_dso  <= n_dso.val;
            r_s6_dy   <= r_s5_dy;
            r_s6_dzp  <= r_s5_dzp;
            r_s6_inr  <= r_s5_inr;
            r_s6_fin  <= r_s5_fin | n_t.clip;
            r_s6_fout <= r_s5_fout | n_dso.clip;

            r_s7_pu   <= r_s6_t * r_ext;
            r_s7_dso  <= r_s6_dso;
            r_s7_dy   <= r_s6_dy;
            r_s7_dzp  <= r_s6_dzp;
            r_s7_inr  <= r_s6_inr;
            r_s7_fin  <= r_s6_fin;
            r_s7_fout <= r_s6_fout;

            r_s8_u    <= n_u.val;
            r_s8_dso  <= r_s7_dso;
            r_s8_dy   <= r_s7_dy;
            r_s8_dzp  <= r_s7_dzp;
            r_s8_inr  <= r_s7_inr;
            r_s8_fin  <= r_s7_fin | n_u.clip;
            r_s8_fout <= r_s7_fout;

            r_s9_pd   <= r_s8_u * g_ext;
            r_s9_dso  <= r_s8_dso;
            r_s9_dy   <= r_s8_dy;
            r_s9_dzp  <= r_s8_dzp;
            r_s9_inr  <= r_s8_inr;
            r_s9_fin  <= r_s8_fin;
            r_s9_fout <= r_s8_fout;

            r_s10_res <= n_res;
        end
    end

    assign o_valid = r_s10_valid;
    assign o_res   = r_s10_res;

endmodule

/* sv/fqlg_skid.sv */
module fqlg_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fqlg_pkg::t_res   i_data,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output fqlg_pkg::t_res   o_data
);

    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    fqlg_pkg::t_res   r_slot0;
    fqlg_pkg::t_res   r_slot1;
    logic             n_pop;

    always_comb begin
        n_pop = (r_cnt != 2'd0) && i_ready;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, n_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // head in slot 0; shift the second word forward on a pop
    always_ff @(posedge i_clk) begin
        if (n_pop) begin
            r_slot0 <= (r_cnt == 2'd2) ? r_slot1 : i_data;
        end else if (i_push && r_cnt == 2'd0) begin
            r_slot0 <= i_data;
        end
        if (i_push && !n_pop && r_cnt == 2'd1) begin
            r_slot1 <= i_data;
        end
    end

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;

endmodule

/* sv/fake_quant_learnable_grad_top.sv */
// Learned-step-size fake-quantization backward step, per tensor. Each input word carries an
// activation x and an upstream gradient dy (signed fixed point with FRAC_BITS fraction bits);
// each output word carries dx, the scale gradient contribution, the zero-point gradient
// contribution and a flag that is set when any intermediate or final value was clipped to the
// signed 32-bit range. The block takes one word per clock while s_tready is high and returns
// one word for each word taken, in order. The pipe is built from five dependent multiplies on
// the in-range path (x*r, q*s, dy*err, t*r, u*g), each followed by its own rounding and
// clipping stage; the output buffer follows the pipe. The two-word output buffer absorbs
// stalls: s_tready only drops once both buffer words are held, or while in reset, and it is
// decoded from a register, not from m_tready. Configuration registers are written through the
// cfg channel, which is ready whenever the block is out of reset; write them only while no word
// is in flight.
module fake_quant_learnable_grad_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] x_value, [63:32] dy_value

    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [31:0] dx_value, [63:32] dscale_value, [95:64] dzp_value
    output logic [0:0]  m_tuser,    // [0] saturated

    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    fqlg_pkg::t_cfg  r_cfg;
    logic            w_en;
    logic            w_mid_valid;
    fqlg_pkg::t_mid  w_mid;
    logic            w_res_valid;
    fqlg_pkg::t_res  w_res;
    fqlg_pkg::t_res  w_out;

    // configuration registers; indices past the list are dropped
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_scale   <= 32'(64'd1 << FRAC_BITS);
            r_cfg.step_inverse <= 32'(64'd1 << FRAC_BITS);
            r_cfg.zero_offset  <= fqlg_pkg::ZERO_OFF_RST;
            r_cfg.level_min    <= fqlg_pkg::LEVEL_MIN_RST;
            r_cfg.level_max    <= fqlg_pkg::LEVEL_MAX_RST;
            r_cfg.grad_gain    <= 32'(64'd1 << FRAC_BITS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fqlg_pkg::CFG_STEP_SCALE:   r_cfg.step_scale   <= i_cfg_data;
                fqlg_pkg::CFG_STEP_INVERSE: r_cfg.step_inverse <= i_cfg_data;
                fqlg_pkg::CFG_ZERO_OFFSET:  r_cfg.zero_offset  <= i_cfg_data[16:0];
                fqlg_pkg::CFG_LEVEL_MIN:    r_cfg.level_min    <= i_cfg_data[16:0];
                fqlg_pkg::CFG_LEVEL_MAX:    r_cfg.level_max    <= i_cfg_data[16:0];
                fqlg_pkg::CFG_GRAD_GAIN:    r_cfg.grad_gain    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // advance the whole pipe whenever the output buffer has room for one more word;
    // hold the input off while in reset
    assign s_tready = w_en && i_rst_n;

    fqlg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_tvalid),
        .i_x     (s_tdata[31:0]),
        .i_dy    (s_tdata[63:32]),
        .i_cfg   (r_cfg),
        .o_valid (w_mid_valid),
        .o_mid   (w_mid)
    );

    fqlg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mid_valid),
        .i_mid   (w_mid),
        .i_cfg   (r_cfg),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    // a finished word leaves the pipe into the buffer on every advancing cycle
    fqlg_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_res_valid),
        .i_data  (w_res),
        .i_ready (m_tready),
        .o_space (w_en),
        .o_valid (m_tvalid),
        .o_data  (w_out)
    );

    assign m_tdata = {w_out.dzp, w_out.dscale, w_out.dx};
    assign m_tuser = w_out.saturated;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Wide enough for every product and sum in the gradient arithmetic, with room to spare
typedef logic signed [127:0] t_acc;

// Tracks the configuration, predicts each gradient word and checks the words that come out
class grad_checker;
    localparam int FRAC = 16;
    localparam t_acc Q_MAX = t_acc'(64'sd2147483647);
    localparam t_acc Q_MIN = t_acc'(-64'sd2147483648);

    t_acc step;
    t_acc inv;
    t_acc zp;
    t_acc lo;
    t_acc hi;
    t_acc gain;
    fqlg_pkg::t_res pending_grads[$];
    int   mismatches;

    function new();
        step       = t_acc'(65536);
        inv        = t_acc'(65536);
        zp         = t_acc'(0);
        lo         = t_acc'(0);
        hi         = t_acc'(255);
        gain       = t_acc'(65536);
        mismatches = 0;
    endfunction

    function void set_reg(fqlg_pkg::t_cfg_idx idx, logic [31:0] v);
        case (idx)
            fqlg_pkg::CFG_STEP_SCALE:   step = t_acc'({1'b0, v});
            fqlg_pkg::CFG_STEP_INVERSE: inv  = t_acc'({1'b0, v});
            fqlg_pkg::CFG_ZERO_OFFSET:  zp   = t_acc'($signed(v[16:0]));
            fqlg_pkg::CFG_LEVEL_MIN:    lo   = t_acc'($signed(v[16:0]));
            fqlg_pkg::CFG_LEVEL_MAX:    hi   = t_acc'($signed(v[16:0]));
            fqlg_pkg::CFG_GRAD_GAIN:    gain = t_acc'({1'b0, v});
            default: ;
        endcase
    endfunction

    // Divide by 2^sh, nearest with ties to even, symmetric about zero
    function t_acc round_even(t_acc v, int sh);
        t_acc mag;
        t_acc q;
        t_acc rem;
        t_acc half;
        bit   neg;
        neg  = v < 0;
        mag  = neg ? -v : v;
        q    = mag >>> sh;
        rem  = mag - (q <<< sh);
        half = t_acc'(1) <<< (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        return neg ? -q : q;
    endfunction

    function t_acc clip32(t_acc v, inout bit flag);
        if (v > Q_MAX) begin
            flag = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            flag = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function t_acc fix_mul(t_acc a, t_acc b, inout bit flag);
        return clip32(round_even(a * b, FRAC), flag);
    endfunction

    // One backward step of learned-step-size fake quantisation
    function fqlg_pkg::t_res lsq_grad(logic signed [31:0] x, logic signed [31:0] dy);
        t_acc wx;
        t_acc wdy;
        t_acc q;
        t_acc xq;
        t_acc err;
        t_acc t;
        t_acc u;
        t_acc v;
        t_acc d;
        t_acc w;
        t_acc dx;
        t_acc ds;
        t_acc dz;
        bit   flag;
        fqlg_pkg::t_res res;
        flag = 1'b0;
        wx   = t_acc'(x);
        wdy  = t_acc'(dy);
        q    = round_even(wx * inv, 2 * FRAC);
        xq   = q + zp;
        if (xq >= lo && xq <= hi) begin
            // rounding error of the level, pushed back through the chain
            err = clip32(q * step - wx, flag);
            t   = fix_mul(wdy, err, flag);
            u   = fix_mul(t, inv, flag);
            ds  = fix_mul(u, gain, flag);
            dz  = 0;
            dx  = wdy;
        end else begin
            v  = fix_mul(wdy, step, flag);
            d  = (xq < lo) ? lo - zp : hi - zp;
            dz = clip32(round_even(-(v * gain), FRAC), flag);
            w  = clip32(wdy * d, flag);
            ds = fix_mul(w, gain, flag);
            dx = 0;
        end
        res.dx        = dx[31:0];
        res.dscale    = ds[31:0];
        res.dzp       = dz[31:0];
        res.saturated = flag;
        return res;
    endfunction

    function void note_word(logic signed [31:0] x, logic signed [31:0] dy);
        pending_grads.push_back(lsq_grad(x, dy));
    endfunction

    function void check_word(fqlg_pkg::t_res got);
        fqlg_pkg::t_res want;
        if (pending_grads.size() == 0) begin
            $error("result word with nothing pending: %h", got);
            mismatches++;
            return;
        end
        want = pending_grads.pop_front();
        if (got.dx !== want.dx) begin
            $error("dx_value: expected %0d, got %0d", want.dx, got.dx);
            mismatches++;
        end
        if (got.dscale !== want.dscale) begin
            $error("dscale_value: expected %0d, got %0d", want.dscale, got.dscale);
            mismatches++;
        end
        if (got.dzp !== want.dzp) begin
            $error("dzp_value: expected %0d, got %0d", want.dzp, got.dzp);
            mismatches++;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int FRAC       = 16;
    localparam int PIPE_SLACK = 16;    // a little beyond the latency of the pipe and buffer
    localparam int RX_HOLD    = 250;   // long receiver hold-off, in cycles
    localparam int WATCHDOG   = 3000;  // cycles with no handshake before giving up

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    grad_checker sb = new();

    // Idling controls shared between the stimulus and the receiver
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;
    int stall_cycles = 0;

    // Directed words at the reset configuration (unit step, levels 0..255): zero, the
    // corners of both fields, rounding ties either side of zero, both ends of the level
    // range and words that clip on the way through
    logic [31:0] dir_x [16] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h0000_8000, 32'h0001_8000, 32'hFFFF_8000,
        32'hFFFE_8000, 32'h00FF_0000, 32'h00FF_8000, 32'h00FE_8000,
        32'hFFFF_7FFF, 32'h0001_2345, 32'h0000_4000, 32'h00FF_7FFF
    };
    logic [31:0] dir_dy [16] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_2345,
        32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
        32'h0003_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000
    };

    fake_quant_learnable_grad_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [31:0] x_value, [63:32] dy_value
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [31:0] dx_value, [63:32] dscale_value, [95:64] dzp_value
        .m_tuser     (m_tuser),     // [0] saturated
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Reciprocal of a step in the same fixed-point format, as software would set it
    function automatic logic [31:0] recip(logic [31:0] s);
        logic [63:0] r;
        r = ((64'd1 << 32) + (s >> 1)) / s;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic int rand_level();
        return int'($urandom_range(0, 98303)) - 32768;
    endfunction

    // Monitor: track configuration writes, update the prediction on every accepted word, check every result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(fqlg_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready)
                sb.check_word(fqlg_pkg::t_res'({m_tuser, m_tdata}));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random stalls, a long hold-off on request, or always ready when calm
    initial begin
        int rx_stall_left;
        int rx_hold_left;
        rx_stall_left = 0;
        rx_hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD;
            end
            if (rx_hold_left > 0) begin
                m_tready = 1'b0;
                rx_hold_left--;
            end else if (rx_calm) begin
                m_tready = 1'b1;
            end else if (rx_stall_left > 0) begin
                m_tready = 1'b0;
                rx_stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 25)
                    rx_stall_left = pick_gap();
            end
        end
    end

    // Watchdog: give up once nothing has moved for too long
    initial begin
        while (stall_cycles < WATCHDOG)
            @(posedge i_clk);
        $display("testbench: done, errors");
        $finish;
    end

    // Offer one word and hold it until the block takes it
    task automatic send_word(logic [31:0] x, logic [31:0] dy);
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = {dy, x};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    task automatic pause_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (sb.pending_grads.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(fqlg_pkg::t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_config(logic [31:0] s, logic [31:0] r, int zp, int lo, int hi,
                               logic [31:0] g);
        drain_results();
        write_reg(fqlg_pkg::CFG_STEP_SCALE, s);
        write_reg(fqlg_pkg::CFG_STEP_INVERSE, r);
        write_reg(fqlg_pkg::CFG_ZERO_OFFSET, 32'(zp));
        write_reg(fqlg_pkg::CFG_LEVEL_MIN, 32'(lo));
        write_reg(fqlg_pkg::CFG_LEVEL_MAX, 32'(hi));
        write_reg(fqlg_pkg::CFG_GRAD_GAIN, g);
    endtask

    task automatic random_config();
        logic [31:0] s;
        logic [31:0] r;
        int          zp;
        int          lo;
        int          hi;
        int          swap;
        s  = $urandom_range(16, 32'h0010_0000);
        r  = ($urandom_range(0, 3) == 0) ? $urandom : recip(s);
        if (r == 0)
            r = 1;
        zp = rand_level();
        lo = rand_level();
        hi = rand_level();
        // keep the level range well formed most of the time
        if (lo > hi && $urandom_range(0, 4) != 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        load_config(s, r, zp, lo, hi, $urandom_range(0, 32'h0004_0000));
    endtask

    // Aim most activations at a level inside or at the edge of the range, the rest anywhere
    task automatic make_item(output logic [31:0] x, output logic [31:0] dy);
        t_acc lvl;
        t_acc xw;
        bit   clipped;
        int   pick;
        pick = $urandom_range(0, 99);
        lvl  = 0;
        if (pick < 55 && sb.lo <= sb.hi) begin
            lvl = sb.lo + t_acc'($urandom_range(0, 32'(sb.hi - sb.lo)));
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: lvl = sb.lo - 1;
                1: lvl = sb.lo;
                2: lvl = sb.hi;
                default: lvl = sb.hi + 1;
            endcase
        end
        if (pick < 80) begin
            xw = (lvl - sb.zp) * sb.step + t_acc'($urandom_range(0, 32'(sb.step)))
                 - (sb.step >>> 1);
            xw = sb.clip32(xw, clipped);
            x  = xw[31:0];
        end else begin
            x = $urandom;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            dy = $urandom;
        end else if (pick < 8) begin
            dy = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        end else begin
            case ($urandom_range(0, 4))
                0: dy = 32'h0000_0000;
                1: dy = 32'h7FFF_FFFF;
                2: dy = 32'h8000_0000;
                3: dy = 32'h0000_0001;
                default: dy = 32'hFFFF_FFFF;
            endcase
        end
    endtask

    task automatic stream_items(int n);
        logic [31:0] x;
        logic [31:0] dy;
        repeat (n) begin
            make_item(x, dy);
            send_word(x, dy);
            if (!tx_calm && $urandom_range(0, 99) < 30)
                pause_sender(pick_gap());
        end
    endtask

    initial begin
        logic [31:0] s;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at the reset configuration
        for (int i = 0; i < 16; i++)
            send_word(dir_x[i], dir_dy[i]);

        // typical unsigned 8-bit activation quantiser
        load_config(32'd3277, recip(32'd3277), 128, 0, 255, 32'h0001_0000);
        stream_items(150);

        // signed 8-bit; hold the receiver off while the sender keeps offering
        load_config(32'h0000_8000, 32'h0002_0000, 0, -128, 127, $urandom_range(0, 32'h0002_0000));
        stream_items(30);
        rx_hold_req = 1'b1;
        tx_calm     = 1'b1;
        stream_items(40);
        tx_calm     = 1'b0;
        stream_items(80);

        // step, reciprocal and gain at their top, wide level range: clipping everywhere
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, -32768, -32768, 65535, 32'hFFFF_FFFF);
        stream_items(100);

        // smallest step and reciprocal, zero gain, zero point at the top level
        load_config(32'd1, 32'd1, 65535, -32768, 65535, 32'd0);
        stream_items(100);

        // empty level range: every word takes one of the clipped branches
        s = $urandom_range(256, 32'h0004_0000);
        load_config(s, recip(s), 0, 100, -100, 32'h0001_0000);
        stream_items(100);

        // back-to-back words with the receiver always ready
        load_config(32'h0001_0000, 32'h0001_0000, -5, -32768, 65535,
                    $urandom_range(0, 32'h0010_0000));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        stream_items(150);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // random settings; the sender pauses for a full drain midway through one
        random_config();
        stream_items(50);
        drain_results();
        stream_items(50);
        random_config();
        stream_items(100);
        random_config();
        stream_items(100);

        drain_results();
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
